[src/crr_pkg.sv]
package crr_pkg;

    localparam int MAX_LINE   = 1024;
    localparam int MAX_OUT    = 4096;
    localparam int FRAC_BITS  = 16;

    localparam int IDX_W      = 10;
    localparam int OUT_IDX_W  = 12;
    localparam int SMP_W      = 16;
    localparam int IN_CNT_W   = 11;
    localparam int OUT_CNT_W  = 13;
    localparam int CFG_W      = 13;

    localparam int DIV_W      = 12;
    localparam int SPAN_W     = OUT_IDX_W + IDX_W;
    localparam int QUO_W      = IDX_W + FRAC_BITS;
    localparam int DIV_STAGES = QUO_W / 2;

    localparam int NBANK      = 4;
    localparam int BANK_W     = 2;
    localparam int ROW_W      = IDX_W - BANK_W;
    localparam int ROWS       = MAX_LINE / NBANK;

    localparam int COEF_W     = 20;
    localparam int ACC_W      = 40;
    localparam int HI_W       = ACC_W - FRAC_BITS;
    localparam int RES_W      = ACC_W - FRAC_BITS - 1;

    localparam logic REG_IN_COUNT  = 1'b0;
    localparam logic REG_OUT_COUNT = 1'b1;

    typedef enum logic [1:0] {
        SEG_MID,
        SEG_FIRST,
        SEG_LAST,
        SEG_END
    } seg_t;

    typedef struct packed {
        logic                    vld;
        logic                    load;
        logic                    fin;
        logic [IDX_W-1:0]        idx;
        logic signed [SMP_W-1:0] val;
    } tag_t;

    typedef struct packed {
        logic                 vld;
        seg_t                 seg;
        logic [BANK_W-1:0]    base_lo;
        logic [FRAC_BITS-1:0] f;
    } rd_ctl_t;

endpackage

[src/crr_div.sv]
module crr_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  crr_pkg::tag_t               tag_i,
    input  logic [crr_pkg::SPAN_W-1:0]  span_i,
    input  logic [crr_pkg::DIV_W-1:0]   d_i,
    output crr_pkg::tag_t               tag_o,
    output logic [crr_pkg::QUO_W-1:0]   q_o
);
    import crr_pkg::*;

    tag_t             tag_reg [DIV_STAGES+1];
    logic [DIV_W-1:0] rem_reg [DIV_STAGES+1];
    logic [QUO_W-1:0] num_reg [DIV_STAGES+1];
    logic [QUO_W-1:0] q_reg   [DIV_STAGES+1];

    // top bits of span start as the partial remainder, rest plus fraction zeros shift in
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg[0] <= '0;
        end
        else if (en)
        begin
            tag_reg[0] <= tag_i;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= span_i[SPAN_W-1:SPAN_W-DIV_W];
            num_reg[0] <= {span_i[SPAN_W-DIV_W-1:0], {FRAC_BITS{1'b0}}};
            q_reg[0]   <= '0;
        end
    end

    genvar s;
    generate
        for (s = 0; s < DIV_STAGES; s++)
        begin : g_stage
            logic [DIV_W:0]   t1, t2;
            logic             ge1, ge2;
            logic [DIV_W-1:0] r1, rem_next;

            // two restoring steps per stage
            always_comb
            begin
                t1       = {rem_reg[s], num_reg[s][QUO_W-1]};
                ge1      = (t1 >= {1'b0, d_i});
                r1       = ge1 ? DIV_W'(t1 - {1'b0, d_i}) : t1[DIV_W-1:0];
                t2       = {r1, num_reg[s][QUO_W-2]};
                ge2      = (t2 >= {1'b0, d_i});
                rem_next = ge2 ? DIV_W'(t2 - {1'b0, d_i}) : t2[DIV_W-1:0];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    tag_reg[s+1] <= '0;
                end
                else if (en)
                begin
                    tag_reg[s+1] <= tag_reg[s];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s+1] <= rem_next;
                    num_reg[s+1] <= {num_reg[s][QUO_W-3:0], 2'b00};
                    q_reg[s+1]   <= {q_reg[s][QUO_W-3:0], ge1, ge2};
                end
            end
        end
    endgenerate

    assign tag_o = tag_reg[DIV_STAGES];
    assign q_o   = q_reg[DIV_STAGES];

endmodule

[src/crr_store.sv]
module crr_store (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  crr_pkg::tag_t                     tag_i,
    input  logic [crr_pkg::QUO_W-1:0]         q_i,
    input  logic [crr_pkg::IDX_W-1:0]         n1_i,
    input  logic [crr_pkg::IDX_W-1:0]         n2_i,
    output crr_pkg::rd_ctl_t                  ctl_o,
    output logic signed [crr_pkg::SMP_W-1:0]  rdata_o [crr_pkg::NBANK]
);
    import crr_pkg::*;

    logic [SMP_W-1:0]     mem [NBANK][ROWS];
    logic [SMP_W-1:0]     rdata_reg [NBANK];
    logic [IDX_W-1:0]     k;
    logic [FRAC_BITS-1:0] f;
    logic [IDX_W-1:0]     base;
    seg_t                 seg;
    logic                 wr;
    rd_ctl_t              ctl_reg;
    rd_ctl_t              ctl_next;

    assign k  = q_i[QUO_W-1:FRAC_BITS];
    assign f  = q_i[FRAC_BITS-1:0];
    assign wr = en && tag_i.vld && tag_i.load;

    always_comb
    begin
        if (tag_i.fin)
            seg = SEG_END;
        else if (k == '0)
            seg = SEG_FIRST;
        else if (k == n2_i)
            seg = SEG_LAST;
        else
            seg = SEG_MID;

        case (seg)
            SEG_END:   base = n1_i;
            SEG_FIRST: base = '0;
            default:   base = IDX_W'(k - 1'b1);
        endcase

        ctl_next.vld     = tag_i.vld && !tag_i.load;
        ctl_next.seg     = seg;
        ctl_next.base_lo = base[BANK_W-1:0];
        ctl_next.f       = f;
    end

    // four banks by address mod 4, so four neighbors are read in the same cycle
    genvar b;
    generate
        for (b = 0; b < NBANK; b++)
        begin : g_bank
            logic [BANK_W-1:0] j;
            logic [IDX_W-1:0]  a;

            assign j = BANK_W'(b) - base[BANK_W-1:0];
            assign a = base + {{(IDX_W-BANK_W){1'b0}}, j};

            always_ff @(posedge clk)
            begin
                if (wr && (tag_i.idx[BANK_W-1:0] == BANK_W'(b)))
                begin
                    mem[b][tag_i.idx[IDX_W-1:BANK_W]] <= tag_i.val;
                end
                if (en)
                begin
                    rdata_reg[b] <= mem[b][a[IDX_W-1:BANK_W]];
                end
            end

            assign rdata_o[b] = $signed(rdata_reg[b]);
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_next;
        end
    end

    assign ctl_o = ctl_reg;

endmodule

[src/crr_horner.sv]
module crr_horner (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  crr_pkg::rd_ctl_t                  ctl_i,
    input  logic signed [crr_pkg::SMP_W-1:0]  rdata_i [crr_pkg::NBANK],
    output logic                              out_valid,
    output logic signed [crr_pkg::SMP_W-1:0]  value,
    output logic                              saturated
);
    import crr_pkg::*;

    function automatic logic signed [ACC_W-1:0] up(input logic signed [COEF_W-1:0] a);
        up = {{(ACC_W-COEF_W-FRAC_BITS){a[COEF_W-1]}}, a, {FRAC_BITS{1'b0}}};
    endfunction

    localparam int STG = 7;

    logic                    vld_reg  [STG];
    logic                    fin_reg  [STG];
    logic signed [SMP_W-1:0] endv_reg [STG];
    logic [FRAC_BITS-1:0]    f_reg    [STG];
    logic signed [COEF_W-1:0] a3_reg, a2_reg, a2b_reg;
    logic signed [COEF_W-1:0] a1_reg [4];
    logic signed [COEF_W-1:0] a0_reg [6];
    logic signed [ACC_W-1:0]  p1_reg, acc1_reg, ph1_reg, acc2_reg, ph2_reg, acc3_reg;
    logic [2*FRAC_BITS-1:0]   pl1_reg, pl2_reg;

    logic signed [SMP_W-1:0]  r [NBANK];
    logic signed [COEF_W-1:0] e0, e1, e2, e3;
    logic signed [COEF_W-1:0] a3_next, a2_next, a1_next, a0_next;
    logic signed [FRAC_BITS:0] fs2, fs4, fs6;
    logic signed [ACC_W-1:0]  adj;
    logic signed [RES_W-1:0]  res;
    logic                     out_valid_reg, sat_reg, sat_next;
    logic signed [SMP_W-1:0]  value_reg, value_next;

    always_comb
    begin
        for (int j = 0; j < NBANK; j++)
        begin
            r[j] = rdata_i[BANK_W'(ctl_i.base_lo + BANK_W'(j))];
        end
        case (ctl_i.seg)
            SEG_FIRST:
            begin
                e0 = COEF_W'(r[0]); e1 = COEF_W'(r[0]);
                e2 = COEF_W'(r[1]); e3 = COEF_W'(r[2]);
            end
            SEG_LAST:
            begin
                e0 = COEF_W'(r[0]); e1 = COEF_W'(r[1]);
                e2 = COEF_W'(r[2]); e3 = COEF_W'(r[2]);
            end
            default:
            begin
                e0 = COEF_W'(r[0]); e1 = COEF_W'(r[1]);
                e2 = COEF_W'(r[2]); e3 = COEF_W'(r[3]);
            end
        endcase
        a3_next = -e0 + (e1 <<< 1) + e1 - (e2 <<< 1) - e2 + e3;
        a2_next = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
        a1_next = e2 - e0;
        a0_next = e1 <<< 1;
    end

    assign fs2 = $signed({1'b0, f_reg[0]});
    assign fs4 = $signed({1'b0, f_reg[2]});
    assign fs6 = $signed({1'b0, f_reg[4]});

    // truncate toward zero by biasing negatives before the shift
    always_comb
    begin
        adj = acc3_reg[ACC_W-1] ? (acc3_reg + ACC_W'((1 << (FRAC_BITS+1)) - 1)) : acc3_reg;
        res = adj[ACC_W-1:FRAC_BITS+1];
        sat_next   = 1'b0;
        value_next = res[SMP_W-1:0];
        if (res > RES_W'(32767))
        begin
            value_next = 16'sh7fff;
            sat_next   = 1'b1;
        end
        else if (res < -RES_W'(32768))
        begin
            value_next = 16'sh8000;
            sat_next   = 1'b1;
        end
        if (fin_reg[STG-1])
        begin
            value_next = endv_reg[STG-1];
            sat_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < STG; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= ctl_i.vld;
            for (int s = 1; s < STG; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
            out_valid_reg <= vld_reg[STG-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fin_reg[0]  <= (ctl_i.seg == SEG_END);
            endv_reg[0] <= r[0];
            f_reg[0]    <= ctl_i.f;
            for (int s = 1; s < STG; s++)
            begin
                fin_reg[s]  <= fin_reg[s-1];
                endv_reg[s] <= endv_reg[s-1];
                f_reg[s]    <= f_reg[s-1];
            end
            a3_reg    <= a3_next;
            a2_reg    <= a2_next;
            a1_reg[0] <= a1_next;
            a0_reg[0] <= a0_next;
            for (int s = 1; s < 4; s++)
            begin
                a1_reg[s] <= a1_reg[s-1];
            end
            for (int s = 1; s < 6; s++)
            begin
                a0_reg[s] <= a0_reg[s-1];
            end
            // first horner step
            p1_reg   <= ACC_W'(a3_reg) * ACC_W'(fs2);
            a2b_reg  <= a2_reg;
            acc1_reg <= p1_reg + up(a2b_reg);
            // floor(acc*f/2^16) as high part times f plus low part times f
            ph1_reg  <= ACC_W'($signed(acc1_reg[ACC_W-1:FRAC_BITS])) * ACC_W'(fs4);
            pl1_reg  <= (2*FRAC_BITS)'(acc1_reg[FRAC_BITS-1:0]) * (2*FRAC_BITS)'(f_reg[2]);
            acc2_reg <= ph1_reg + ACC_W'(pl1_reg[2*FRAC_BITS-1:FRAC_BITS]) + up(a1_reg[3]);
            ph2_reg  <= ACC_W'($signed(acc2_reg[ACC_W-1:FRAC_BITS])) * ACC_W'(fs6);
            pl2_reg  <= (2*FRAC_BITS)'(acc2_reg[FRAC_BITS-1:0]) * (2*FRAC_BITS)'(f_reg[4]);
            acc3_reg <= ph2_reg + ACC_W'(pl2_reg[2*FRAC_BITS-1:FRAC_BITS]) + up(a0_reg[5]);
            value_reg <= value_next;
            sat_reg   <= sat_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign saturated = sat_reg;

endmodule

[src/catmull_rom_line_resampler_top.sv]
// Catmull-Rom line resampler. Load words (cmd 0) write one sample into a 1024-entry line
// store; request words (cmd 1) return one interpolated sample for out_index. One word is
// taken every clock while the output is not stalled, and a request passes through the
// pipelined divider that forms the position (two quotient bits per stage), the four-bank
// line store and the Horner multiply pipeline. Loads travel the same pipeline and write
// the store at its read stage, so requests always see the loads taken before them. A
// stalled output freezes the whole pipeline. Set in_count and out_count only while no
// word is in flight.
module catmull_rom_line_resampler_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                cmd,
    input  logic [crr_pkg::IDX_W-1:0]           sample_index,
    input  logic signed [crr_pkg::SMP_W-1:0]    sample_value,
    input  logic [crr_pkg::OUT_IDX_W-1:0]       out_index,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [crr_pkg::SMP_W-1:0]    value,
    output logic                                saturated,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic                                cfg_index,
    input  logic [crr_pkg::CFG_W-1:0]           cfg_data
);
    import crr_pkg::*;

    logic [IN_CNT_W-1:0]  in_count_reg;
    logic [OUT_CNT_W-1:0] out_count_reg;
    logic [IN_CNT_W-1:0]  n_cl;
    logic [OUT_CNT_W-1:0] m_cl;
    logic [IDX_W-1:0]     n1, n2;
    logic [DIV_W-1:0]     d;
    logic                 en;
    logic                 fin;
    logic [SPAN_W-1:0]    span;
    tag_t                 tag_in, div_tag;
    logic [QUO_W-1:0]     div_q;
    rd_ctl_t              rd_ctl;
    logic signed [SMP_W-1:0] rdata [NBANK];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_count_reg  <= IN_CNT_W'(MAX_LINE);
            out_count_reg <= OUT_CNT_W'(1024);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_IN_COUNT:  in_count_reg  <= cfg_data[IN_CNT_W-1:0];
                REG_OUT_COUNT: out_count_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        if (in_count_reg < IN_CNT_W'(3))
            n_cl = IN_CNT_W'(3);
        else if (in_count_reg > IN_CNT_W'(MAX_LINE))
            n_cl = IN_CNT_W'(MAX_LINE);
        else
            n_cl = in_count_reg;
        if (out_count_reg < OUT_CNT_W'(2))
            m_cl = OUT_CNT_W'(2);
        else if (out_count_reg > OUT_CNT_W'(MAX_OUT))
            m_cl = OUT_CNT_W'(MAX_OUT);
        else
            m_cl = out_count_reg;
    end

    assign n1 = IDX_W'(n_cl - 1'b1);
    assign n2 = IDX_W'(n_cl - 2'd2);
    assign d  = DIV_W'(m_cl - 1'b1);

    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    assign fin  = (out_index >= d);
    assign span = fin ? '0 : SPAN_W'(out_index) * SPAN_W'(n1);

    always_comb
    begin
        tag_in.vld  = in_valid;
        tag_in.load = !cmd;
        tag_in.fin  = fin;
        tag_in.idx  = sample_index;
        tag_in.val  = sample_value;
    end

    crr_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .tag_i  (tag_in),
        .span_i (span),
        .d_i    (d),
        .tag_o  (div_tag),
        .q_o    (div_q)
    );

    crr_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .tag_i   (div_tag),
        .q_i     (div_q),
        .n1_i    (n1),
        .n2_i    (n2),
        .ctl_o   (rd_ctl),
        .rdata_o (rdata)
    );

    crr_horner u_horner (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .ctl_i     (rd_ctl),
        .rdata_i   (rdata),
        .out_valid (out_valid),
        .value     (value),
        .saturated (saturated)
    );

    a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> value == 16'sh7fff || value == 16'sh8000)
        else $error("saturated result off the rail");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("input taken while output blocked");

endmodule

[tb/sv/tb.sv]
module tb;
    import crr_pkg::*;

    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        logic signed [SMP_W-1:0] v;
        logic                    s;
    } sample_res_t;

    typedef struct {
        logic                    c;
        logic [IDX_W-1:0]        idx;
        logic signed [SMP_W-1:0] val;
        logic [OUT_IDX_W-1:0]    oidx;
        bit                      typed;
        sample_res_t             want;
    } dir_row_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic                        cmd = 1'b0;
    logic [IDX_W-1:0]            sample_index = '0;
    logic signed [SMP_W-1:0]     sample_value = '0;
    logic [OUT_IDX_W-1:0]        out_index = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic signed [SMP_W-1:0]     value;
    logic                        saturated;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic                        cfg_index = REG_IN_COUNT;
    logic [CFG_W-1:0]            cfg_data = '0;

    logic signed [SMP_W-1:0]     line_mirror [MAX_LINE];
    bit                          written [MAX_LINE];
    logic [IN_CNT_W-1:0]         in_cnt_reg = 11'd1024;
    logic [OUT_CNT_W-1:0]        out_cnt_reg = 13'd1024;
    sample_res_t                 expected_samples [$];
    int                          errors = 0;
    int                          idle_cycles = 0;
    int                          burst_left = 0;
    bit                          hold_req = 1'b0;

    catmull_rom_line_resampler_top u_top (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int line_len();
        int n;
        n = in_cnt_reg;
        if (n < 3) n = 3;
        if (n > MAX_LINE) n = MAX_LINE;
        return n;
    endfunction

    function automatic int out_len();
        int m;
        m = out_cnt_reg;
        if (m < 2) m = 2;
        if (m > MAX_OUT) m = MAX_OUT;
        return m;
    endfunction

    function automatic sample_res_t resample_point(int i);
        sample_res_t r;
        int n, m, k;
        longint span, f, c0, c1, c2, c3, a3, a2, a1, a0, acc, mag, res;
        n = line_len();
        m = out_len();
        r.s = 1'b0;
        if (i >= m - 1)
        begin
            r.v = line_mirror[n-1];
            return r;
        end
        span = longint'(i) * (n - 1);
        k = int'(span / (m - 1));
        f = ((span % (m - 1)) << FRAC_BITS) / (m - 1);
        c0 = line_mirror[(k == 0) ? 0 : k - 1];
        c1 = line_mirror[k];
        c2 = line_mirror[k+1];
        c3 = line_mirror[(k == n - 2) ? k + 1 : k + 2];
        a3 = -c0 + 3 * c1 - 3 * c2 + c3;
        a2 = 2 * c0 - 5 * c1 + 4 * c2 - c3;
        a1 = c2 - c0;
        a0 = 2 * c1;
        // arithmetic shift gives the floor division
        acc = a3 * f + (a2 <<< FRAC_BITS);
        acc = ((acc * f) >>> FRAC_BITS) + (a1 <<< FRAC_BITS);
        acc = ((acc * f) >>> FRAC_BITS) + (a0 <<< FRAC_BITS);
        mag = (acc < 0) ? -acc : acc;
        res = mag / (longint'(2) << FRAC_BITS);
        if (acc < 0) res = -res;
        if (res > 32767)
        begin
            res = 32767;
            r.s = 1'b1;
        end
        if (res < -32768)
        begin
            res = -32768;
            r.s = 1'b1;
        end
        r.v = res[SMP_W-1:0];
        return r;
    endfunction

    function automatic int pick_value();
        case ($urandom_range(0, 3))
            0: return -32768;
            1: return 32767;
            default: return int'($signed(16'($urandom)));
        endcase
    endfunction

    // caller sits at a rising edge; returns at the edge the word is taken
    task automatic send_word(logic c, logic [IDX_W-1:0] idx, logic signed [SMP_W-1:0] val,
                             logic [OUT_IDX_W-1:0] oidx, bit typed, sample_res_t want);
        in_valid <= 1'b1;
        cmd <= c;
        sample_index <= idx;
        sample_value <= val;
        out_index <= oidx;
        do @(posedge clk); while (in_stall);
        if (c == 1'b0)
        begin
            line_mirror[idx] = val;
            written[idx] = 1'b1;
        end
        else if (typed)
            expected_samples.push_back(want);
        else
            expected_samples.push_back(resample_point(oidx));
    endtask

    task automatic send_load(int idx, int val);
        sample_res_t none;
        send_word(1'b0, idx[IDX_W-1:0], val[SMP_W-1:0], '0, 1'b0, none);
    endtask

    task automatic send_req(int oidx);
        sample_res_t none;
        int n, m, k, lo, hi, j;
        longint span;
        n = line_len();
        m = out_len();
        if (oidx >= m - 1)
        begin
            lo = n - 1;
            hi = n - 1;
        end
        else
        begin
            span = longint'(oidx) * (n - 1);
            k = int'(span / (m - 1));
            lo = (k == 0) ? 0 : k - 1;
            hi = (k == n - 2) ? k + 1 : k + 2;
        end
        // load every neighbor this request reads that was never written
        for (j = lo; j <= hi; j++)
            if (!written[j])
                send_load(j, pick_value());
        send_word(1'b1, '0, '0, oidx[OUT_IDX_W-1:0], 1'b0, none);
    endtask

    task automatic burst_gap();
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
    endtask

    task automatic write_reg(logic ri, int data);
        cfg_valid <= 1'b1;
        cfg_index <= ri;
        cfg_data <= data[CFG_W-1:0];
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (ri == REG_IN_COUNT)
            in_cnt_reg = data[IN_CNT_W-1:0];
        else
            out_cnt_reg = data[OUT_CNT_W-1:0];
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // receiver: random stall patterns, plus one long hold-off on request
    initial
    begin
        int mode, span, cnt;
        forever
        begin
            if (hold_req)
            begin
                out_stall <= 1'b1;
                for (cnt = 0; cnt < 400; cnt++) @(posedge clk);
                hold_req = 1'b0;
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(5, 60);
            for (cnt = 0; cnt < span && !hold_req; cnt++)
            begin
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 1) == 0);
                    default: out_stall <= (cnt % 4 != 0);
                endcase
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        sample_res_t e;
        if (out_valid && !out_stall)
        begin
            if (expected_samples.size() == 0)
            begin
                $display("%0t: unexpected word value=%0d saturated=%0b",
                         $time, value, saturated);
                errors++;
            end
            else
            begin
                e = expected_samples.pop_front();
                if (value !== e.v)
                begin
                    $display("%0t: value expected %0d actual %0d", $time, e.v, value);
                    errors++;
                end
                if (saturated !== e.s)
                begin
                    $display("%0t: saturated expected %0b actual %0b",
                             $time, e.s, saturated);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT)
        begin
            $display("[catmull_rom_line_resampler_top] ERROR");
            $finish;
        end
    end

    initial
    begin
        dir_row_t dir_rows [$];
        int in_set [7];
        int out_set [7];
        int p, j, n, m;
        in_set = '{3, 1024, 0, 2047, 5, 37, 700};
        out_set = '{2, 4096, 8191, 1, 13, 100, 3000};
        // n = 4, m = 7: first segment, middle, last segment, end and beyond
        dir_rows = '{
            '{1'b0, 10'd0,    -16'sd32768, 12'd0,    0, '{0, 0}},
            '{1'b0, 10'd1,    16'sd32767,  12'd0,    0, '{0, 0}},
            '{1'b0, 10'd2,    -16'sd32768, 12'd0,    0, '{0, 0}},
            '{1'b0, 10'd3,    16'sd32767,  12'd0,    0, '{0, 0}},
            '{1'b0, 10'd1023, 16'sd0,      12'd0,    0, '{0, 0}},
            '{1'b0, 10'd512,  -16'sd1,     12'd0,    0, '{0, 0}},
            '{1'b1, 10'd0,    16'sd0,      12'd0,    1, '{-16'sd32768, 1'b0}},
            '{1'b1, 10'd0,    16'sd0,      12'd1,    0, '{0, 0}},
            '{1'b1, 10'd0,    16'sd0,      12'd2,    0, '{0, 0}},
            '{1'b1, 10'd0,    16'sd0,      12'd3,    0, '{0, 0}},
            '{1'b1, 10'd0,    16'sd0,      12'd4,    0, '{0, 0}},
            '{1'b1, 10'd0,    16'sd0,      12'd5,    0, '{0, 0}},
            '{1'b1, 10'd0,    16'sd0,      12'd6,    1, '{16'sd32767, 1'b0}},
            '{1'b1, 10'd0,    16'sd0,      12'd2048, 1, '{16'sd32767, 1'b0}},
            '{1'b1, 10'd0,    16'sd0,      12'd4095, 1, '{16'sd32767, 1'b0}}
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(REG_IN_COUNT, 4);
        write_reg(REG_OUT_COUNT, 7);
        foreach (dir_rows[r])
            send_word(dir_rows[r].c, dir_rows[r].idx, dir_rows[r].val, dir_rows[r].oidx,
                      dir_rows[r].typed, dir_rows[r].want);
        drain();

        for (p = 0; p < 7; p++)
        begin
            write_reg(REG_IN_COUNT, in_set[p]);
            write_reg(REG_OUT_COUNT, out_set[p]);
            n = line_len();
            m = out_len();
            if (p == 2)
                hold_req = 1'b1;
            for (j = 0; j < 60; j++)
            begin
                burst_gap();
                case ($urandom_range(0, 9))
                    0: send_load($urandom_range(0, MAX_LINE - 1), pick_value());
                    1, 2: send_load($urandom_range(0, n - 1), pick_value());
                    3: send_req($urandom_range(0, MAX_OUT - 1));
                    default: send_req($urandom_range(0, m - 1));
                endcase
            end
            drain();
        end

        if (errors == 0)
            $display("[catmull_rom_line_resampler_top] OK");
        else
            $display("[catmull_rom_line_resampler_top] ERROR");
        $finish;
    end

endmodule

[sim.f]
src/crr_pkg.sv
src/crr_div.sv
src/crr_store.sv
src/crr_horner.sv
src/catmull_rom_line_resampler_top.sv
tb/sv/tb.sv
